@@ rtl/cuh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cuh_pkg
// shared types and constants of the codon usage histogram
// ----------------------------------------------------------------------------
package cuh_pkg;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_START = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    // register indexes (byte address / 4)
    localparam logic REG_DICODON = 1'b0;
    localparam logic REG_SKIP    = 1'b1;

    // rolling window sizes
    localparam logic [2:0] CODON_BASES   = 3'd3;
    localparam logic [2:0] DICODON_BASES = 3'd6;
    localparam logic [1:0] LAST_PHASE    = 2'd2;

    // bins that collect codons with an ambiguous base
    localparam logic [12:0] CODON_EXTRA_BIN   = 13'd64;
    localparam logic [12:0] DICODON_EXTRA_BIN = 13'd4096;

    // input field widths
    localparam int NUC_WIDTH = 3;
    localparam int BIN_WIDTH = 13;

endpackage : cuh_pkg
`default_nettype wire

@@ rtl/cuh_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cuh_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cuh_ram #(
    parameter int WIDTH      = 32,
    parameter int DEPTH      = 4097,
    parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [ADDR_WIDTH-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]      i_wr_data,
    input  wire logic [ADDR_WIDTH-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule : cuh_ram
`default_nettype wire

@@ rtl/codon_usage_histogram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// codon_usage_histogram
// codon / dicodon usage counter with per-sequence and running-total stores
// ----------------------------------------------------------------------------
// throughput: one beat per cycle for base and read beats unless a read waits on
//   a full output register; a start beat holds the input while the sequence store is swept
// path: a read beat passes the data stage, whose ram read is registered, and then
//   the output register; a count increment is written to the stores from the data stage
// reset: synchronous, active low; afterwards both stores are swept to zero
//   with s_axis_tready low, config writes still taken
// ----------------------------------------------------------------------------
module codon_usage_histogram #(
    parameter int COUNT_WIDTH = 32,
    parameter int BIN_COUNT   = 4097
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // nucleotide[2:0], bin_index[15:3]
    input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
    input  wire logic        s_axis_tlast,  // is_last

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,  // sequence_count[31:0], total_count[63:32]

    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import cuh_pkg::*;

    localparam int AW = $clog2(BIN_COUNT);
    localparam logic [BIN_WIDTH-1:0] BIN_LIMIT = BIN_WIDTH'(BIN_COUNT);
    localparam logic [AW-1:0]        LAST_ADDR = AW'(BIN_COUNT - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic r_dicodon;
    logic r_skip;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dicodon <= 1'b0;
            r_skip    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DICODON: r_dicodon <= pwdata[0];
                REG_SKIP:    r_skip    <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DICODON: prdata = {31'd0, r_dicodon};
            REG_SKIP:    prdata = {31'd0, r_skip};
            default:     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // input fields
    // ------------------------------------------------------------------
    t_mode                in_mode;
    logic [NUC_WIDTH-1:0] in_nuc;
    logic [BIN_WIDTH-1:0] in_bin;
    logic                 s_acc;

    assign in_mode = t_mode'(s_axis_tuser);
    assign in_nuc  = s_axis_tdata[NUC_WIDTH-1:0];
    assign in_bin  = s_axis_tdata[NUC_WIDTH+BIN_WIDTH-1:NUC_WIDTH];
    assign s_acc   = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // rolling codon state
    // ------------------------------------------------------------------
    logic [11:0] r_idx;
    logic [5:0]  r_win;
    logic [2:0]  r_seen;
    logic [1:0]  r_phase;
    logic        r_first;

    logic [11:0]          n_idx;
    logic [5:0]           n_win;
    logic [2:0]           n_seen;
    logic [1:0]           n_phase;
    logic                 base_amb;
    logic                 codon_done;
    logic                 window_amb;
    logic [BIN_WIDTH-1:0] push_bin;
    logic                 push_inc;

    always_comb begin
        // codes four and up are ambiguous, recorded as base zero
        base_amb   = in_nuc[2];
        n_win      = {r_win[4:0], base_amb};
        n_idx      = {r_idx[9:0], (base_amb ? 2'd0 : in_nuc[1:0])};
        n_seen     = (r_seen < DICODON_BASES) ? r_seen + 3'd1 : r_seen;
        n_phase    = (r_phase >= LAST_PHASE) ? 2'd0 : r_phase + 2'd1;

        codon_done = (n_phase == 2'd0)
                  && (n_seen >= (r_dicodon ? DICODON_BASES : CODON_BASES))
                  && !(r_skip && (r_first || s_axis_tlast));
        window_amb = r_dicodon ? (n_win != 6'd0) : (n_win[2:0] != 3'd0);

        if (window_amb) begin
            push_bin = r_dicodon ? DICODON_EXTRA_BIN : CODON_EXTRA_BIN;
        end else if (r_dicodon) begin
            push_bin = {1'b0, n_idx};
        end else begin
            push_bin = {7'd0, n_idx[5:0]};
        end
        // bins past the store are dropped
        push_inc = codon_done && (push_bin < BIN_LIMIT);
    end

    // ------------------------------------------------------------------
    // clearing sweep, pipeline and output control
    // ------------------------------------------------------------------
    logic          r_clr_busy;    // sweep in progress
    logic          r_clr_total;   // sweep also clears the running totals
    logic [AW-1:0] r_clr_addr;

    logic          r_b_valid;     // beat in the ram-data stage
    logic          r_b_inc;       // 1 increment, 0 read
    logic          r_b_oob;       // read of a bin past the store
    logic [AW-1:0] r_b_addr;

    logic                   r_fw_valid;  // last written bin and its counts
    logic [AW-1:0]          r_fw_addr;
    logic [COUNT_WIDTH-1:0] r_fw_seq;
    logic [COUNT_WIDTH-1:0] r_fw_tot;

    logic        r_out_valid;
    logic [31:0] r_out_seq;
    logic [31:0] r_out_tot;

    logic                   b_stall;
    logic                   b_wr;
    logic                   out_load;
    logic                   is_push;
    logic                   is_start;
    logic                   is_read;
    logic [AW-1:0]          a_addr;
    logic [AW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] ram_seq;
    logic [COUNT_WIDTH-1:0] ram_tot;
    logic [COUNT_WIDTH-1:0] seq_cur;
    logic [COUNT_WIDTH-1:0] tot_cur;
    logic [COUNT_WIDTH-1:0] seq_new;
    logic [COUNT_WIDTH-1:0] tot_new;
    logic [63:0]            seq_ext;
    logic [63:0]            tot_ext;
    logic                   fw_hit;

    always_comb begin
        is_push  = 1'b0;
        is_start = 1'b0;
        is_read  = 1'b0;
        unique case (in_mode)
            MODE_PUSH:  is_push  = 1'b1;
            MODE_START: is_start = 1'b1;
            MODE_READ:  is_read  = 1'b1;
            default:    ;
        endcase
    end

    // a read waiting for a full output register holds the whole front
    assign b_stall  = r_b_valid && !r_b_inc && r_out_valid && !m_axis_tready;
    assign out_load = r_b_valid && !r_b_inc && (!r_out_valid || m_axis_tready);
    assign b_wr     = r_b_valid && r_b_inc;

    assign s_axis_tready = !r_clr_busy && !b_stall;

    assign a_addr  = is_read ? in_bin[AW-1:0] : push_bin[AW-1:0];
    // ram address is held while the data stage stalls
    assign rd_addr = s_acc ? a_addr : r_b_addr;

    // forward the last count written, the ram gives the old one on a read that meets its write
    assign fw_hit  = r_fw_valid && (r_fw_addr == r_b_addr);
    assign seq_cur = fw_hit ? r_fw_seq : ram_seq;
    assign tot_cur = fw_hit ? r_fw_tot : ram_tot;
    assign seq_new = (seq_cur == CNT_MAX) ? seq_cur : seq_cur + 1'b1;
    assign tot_new = (tot_cur == CNT_MAX) ? tot_cur : tot_cur + 1'b1;
    assign seq_ext = 64'(seq_cur);
    assign tot_ext = 64'(tot_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_win       <= '0;
            r_seen      <= '0;
            r_phase     <= '0;
            r_first     <= 1'b1;
            r_clr_busy  <= 1'b1;
            r_clr_total <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // rolling state
            if (s_acc && is_push) begin
                r_idx   <= n_idx;
                r_win   <= n_win;
                r_seen  <= n_seen;
                r_phase <= n_phase;
                if (n_phase == 2'd0) begin
                    r_first <= 1'b0;
                end
            end else if (s_acc && is_start) begin
                r_idx   <= '0;
                r_win   <= '0;
                r_seen  <= '0;
                r_phase <= '0;
                r_first <= 1'b1;
            end

            // clearing sweep
            if (r_clr_busy) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy  <= 1'b0;
                    r_clr_total <= 1'b0;
                    r_clr_addr  <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end else if (s_acc && is_start) begin
                r_clr_busy <= 1'b1;
            end

            // data stage
            if (s_acc) begin
                r_b_valid <= is_read || (is_push && push_inc);
            end else if (!b_stall) begin
                r_b_valid <= 1'b0;
            end

            // forwarding, stale once the sequence store is swept
            if (s_acc && is_start) begin
                r_fw_valid <= 1'b0;
            end else if (b_wr) begin
                r_fw_valid <= 1'b1;
            end

            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_b_addr <= a_addr;
            r_b_inc  <= is_push;
            r_b_oob  <= !(in_bin < BIN_LIMIT);
        end
        if (b_wr) begin
            r_fw_addr <= r_b_addr;
            r_fw_seq  <= seq_new;
            r_fw_tot  <= tot_new;
        end
        if (out_load) begin
            // counts wider than the field clip to all ones
            r_out_seq <= r_b_oob ? 32'd0 : ((|seq_ext[63:32]) ? 32'hFFFF_FFFF : seq_ext[31:0]);
            r_out_tot <= r_b_oob ? 32'd0 : ((|tot_ext[63:32]) ? 32'hFFFF_FFFF : tot_ext[31:0]);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_tot, r_out_seq};

    // ------------------------------------------------------------------
    // count stores
    // ------------------------------------------------------------------
    logic                   seq_wr_en;
    logic                   tot_wr_en;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] seq_wr_data;
    logic [COUNT_WIDTH-1:0] tot_wr_data;

    assign seq_wr_en   = r_clr_busy || b_wr;
    assign tot_wr_en   = (r_clr_busy && r_clr_total) || b_wr;
    assign wr_addr     = r_clr_busy ? r_clr_addr : r_b_addr;
    assign seq_wr_data = r_clr_busy ? '0 : seq_new;
    assign tot_wr_data = r_clr_busy ? '0 : tot_new;

    cuh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT)
    ) u_seq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (seq_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (seq_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_seq)
    );

    cuh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT)
    ) u_tot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tot_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (tot_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_tot)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_clr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("input taken during clearing sweep");

    a_start_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_start) |=> r_clr_busy)
        else $error("start beat did not begin a sweep");

    a_no_wr_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && b_wr))
        else $error("count write collides with clearing sweep");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stall |=> (r_b_valid && !r_b_inc && $stable(r_b_addr)))
        else $error("stalled read lost its bin");

endmodule : codon_usage_histogram
`default_nettype wire

@@ tb/sv/codon_count_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codon_count_checker
// watches the input, result and register channels of the codon usage
// histogram, keeps its own copy of both count stores and compares every
// result beat with the counts predicted for the oldest pending read
// ----------------------------------------------------------------------------
module codon_count_checker #(
    parameter int BIN_COUNT = 4097
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,   // nucleotide[2:0], bin_index[15:3]
    input  wire logic [1:0]  i_s_tuser,   // mode[1:0]
    input  wire logic        i_s_tlast,   // is_last

    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,   // sequence_count[31:0], total_count[63:32]

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,

    output int               o_fail_count,
    output int               o_pending
);

    import cuh_pkg::*;

    localparam logic [2:0] AMBIG_CODE = 3'd4;

    logic        dicodon_cfg;
    logic        skip_cfg;
    logic [11:0] roll_idx;
    logic [5:0]  amb_win;
    logic [2:0]  seen;
    logic [1:0]  codon_phase;
    logic        first_pending;
    logic [31:0] seq_counts [BIN_COUNT];
    logic [31:0] tot_counts [BIN_COUNT];

    // {total, sequence} per outstanding read
    logic [63:0] expected_counts [$];
    logic [63:0] exp_beat;
    logic [12:0] rd_bin;
    int          fail_count;

    function automatic void bump_bin(input logic [12:0] bin);
        if (bin < BIN_COUNT) begin
            if (seq_counts[bin] != '1) seq_counts[bin] = seq_counts[bin] + 32'd1;
            if (tot_counts[bin] != '1) tot_counts[bin] = tot_counts[bin] + 32'd1;
        end
    endfunction

    function automatic void restart_sequence();
        roll_idx      = '0;
        amb_win       = '0;
        seen          = '0;
        codon_phase   = '0;
        first_pending = 1'b1;
        for (int b = 0; b < BIN_COUNT; b++) seq_counts[b] = '0;
    endfunction

    function automatic void count_base(input logic [2:0] nuc, input logic last);
        logic        amb;
        logic [2:0]  need;
        logic [5:0]  win_mask;
        logic [12:0] bin;
        logic        was_first;
        amb      = (nuc >= AMBIG_CODE);
        amb_win  = {amb_win[4:0], amb};
        roll_idx = {roll_idx[9:0], (amb ? 2'b00 : nuc[1:0])};
        if (seen < DICODON_BASES) seen = seen + 3'd1;
        codon_phase = (codon_phase == LAST_PHASE) ? 2'd0 : codon_phase + 2'd1;
        if (codon_phase != 2'd0) return;
        was_first     = first_pending;
        first_pending = 1'b0;
        need     = dicodon_cfg ? DICODON_BASES : CODON_BASES;
        win_mask = dicodon_cfg ? 6'h3F : 6'h07;
        if (seen < need) return;
        // skip-ends drops the first codon and the one closing the sequence
        if (skip_cfg && (was_first || last)) return;
        if ((amb_win & win_mask) != 6'd0)
            bin = dicodon_cfg ? DICODON_EXTRA_BIN : CODON_EXTRA_BIN;
        else
            bin = dicodon_cfg ? {1'b0, roll_idx} : {7'd0, roll_idx[5:0]};
        bump_bin(bin);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dicodon_cfg = 1'b0;
            skip_cfg    = 1'b0;
            restart_sequence();
            for (int b = 0; b < BIN_COUNT; b++) tot_counts[b] = '0;
            expected_counts.delete();
            fail_count = 0;
        end else begin
            // result beats are older than any read taken in this cycle
            if (i_m_tvalid && i_m_tready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got seq %0d total %0d",
                             $time, i_m_tdata[31:0], i_m_tdata[63:32]);
                    fail_count++;
                end else begin
                    exp_beat = expected_counts.pop_front();
                    if (i_m_tdata[31:0] !== exp_beat[31:0]) begin
                        $display("%0t: sequence_count mismatch, expected %0d, got %0d",
                                 $time, exp_beat[31:0], i_m_tdata[31:0]);
                        fail_count++;
                    end
                    if (i_m_tdata[63:32] !== exp_beat[63:32]) begin
                        $display("%0t: total_count mismatch, expected %0d, got %0d",
                                 $time, exp_beat[63:32], i_m_tdata[63:32]);
                        fail_count++;
                    end
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_DICODON: dicodon_cfg = i_pwdata[0];
                    REG_SKIP:    skip_cfg    = i_pwdata[0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    MODE_PUSH:  count_base(i_s_tdata[2:0], i_s_tlast);
                    MODE_START: restart_sequence();
                    MODE_READ: begin
                        rd_bin = i_s_tdata[15:3];
                        // bins past the store read back as zero
                        if (rd_bin < BIN_COUNT)
                            expected_counts.push_back({tot_counts[rd_bin], seq_counts[rd_bin]});
                        else
                            expected_counts.push_back(64'd0);
                    end
                    default: ;
                endcase
            end
        end
        o_pending    = expected_counts.size();
        o_fail_count = fail_count;
    end

endmodule : codon_count_checker

@@ tb/sv/tb_codon_usage_histogram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_codon_usage_histogram
// drives base, start and read beats plus register writes into the codon
// usage histogram with random idling on both streams; the checker beside
// the block predicts every read and reports mismatches
// ----------------------------------------------------------------------------
module tb_codon_usage_histogram;

    import cuh_pkg::*;

    // mode code the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // longest quiet stretch: a sequence store sweep plus the long hold
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 88;
    localparam int PHASE_COUNT    = 8;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // nucleotide[2:0], bin_index[15:3]
    logic [1:0]  s_axis_tuser  = '0;   // mode[1:0]
    logic        s_axis_tlast  = 1'b0; // is_last

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // sequence_count[31:0], total_count[63:32]

    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;

    // idling controls for both streams and the long-hold controls of the result sink
    logic        tx_idle_on    = 1'b0;
    logic        rx_idle_on    = 1'b0;
    logic        hold_req      = 1'b0;
    logic        hold_done     = 1'b0;

    // current dicodon setting and the last six base codes sent
    logic        cfg_dicodon   = 1'b0;
    logic [11:0] recent_codes  = '0;

    codon_usage_histogram uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    codon_count_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one input beat; entered and left at a falling edge with no drive left there
    task automatic send_beat(input logic [1:0] kind, input logic [2:0] nuc,
                             input logic last, input logic [12:0] bin);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {bin, nuc};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // base beat with a random, unused bin field
    task automatic send_base(input logic [2:0] nuc, input logic last);
        recent_codes = {recent_codes[9:0], (nuc[2] ? 2'b00 : nuc[1:0])};
        send_beat(MODE_PUSH, nuc, last, 13'($urandom_range(0, 8191)));
    endtask

    // read beat with random, unused base and last fields
    task automatic send_read(input logic [12:0] bin);
        send_beat(MODE_READ, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), bin);
    endtask

    // most often bins that were just filled, then the extra bin, out-of-range bins
    // and plain random ones
    function automatic logic [12:0] pick_read_bin();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return cfg_dicodon ? {1'b0, recent_codes} : {7'd0, recent_codes[5:0]};
        if (r < 11)
            return cfg_dicodon ? DICODON_EXTRA_BIN : CODON_EXTRA_BIN;
        if (r < 12)
            return 13'($urandom_range(4097, 8191));
        return cfg_dicodon ? 13'($urandom_range(0, 4095)) : 13'($urandom_range(0, 63));
    endfunction

    // register write: setup phase then access phase, then the bus is left idle
    task automatic write_reg(input logic idx, input logic bit_val);
        logic [31:0] wdata;
        wdata    = $urandom;
        wdata[0] = bit_val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // drop the input, wait for all reads to come back and the block to be
    // ready, then let in-flight increments land
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || !s_axis_tready) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // a sequence with random content, mostly whole codons with the last mark
    // on the final base; reads scattered between the bases
    task automatic run_sequence();
        int         nbases;
        logic [2:0] nuc;
        if ($urandom_range(0, 4) != 0)
            send_beat(MODE_START, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      13'($urandom_range(0, 8191)));
        nbases = 3 * $urandom_range(1, 8);
        if ($urandom_range(0, 7) == 0) nbases += $urandom_range(1, 2);
        for (int i = 0; i < nbases; i++) begin
            if ($urandom_range(0, 11) == 0)
                nuc = 3'($urandom_range(4, 7));
            else
                nuc = 3'($urandom_range(0, 3));
            send_base(nuc, i == nbases - 1);
            if ($urandom_range(0, 3) == 0) send_read(pick_read_bin());
        end
    endtask

    // broken or stray beats
    task automatic run_noise();
        case ($urandom_range(0, 3))
            0: send_beat(MODE_UNUSED, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         13'($urandom_range(0, 8191)));
            1: send_read(13'($urandom_range(0, 8191)));
            2: send_base(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            default: begin
                send_beat(MODE_START, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          13'($urandom_range(0, 8191)));
                send_read(pick_read_bin());
            end
        endcase
    endtask

    initial begin : stimulus
        int phase_end;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers can be written while the stores are swept after reset
        write_reg(REG_DICODON, 1'b0);
        write_reg(REG_SKIP, 1'b0);
        cfg_dicodon = 1'b0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;

        // directed: codon mode, ends counted
        send_read(13'd0);
        send_base(3'd0, 1'b0);
        send_base(3'd1, 1'b0);
        send_base(3'd2, 1'b0);
        send_base(3'd3, 1'b0);
        send_base(3'd3, 1'b0);
        send_base(3'd3, 1'b1);
        // ambiguous codes, including the ones above 4
        send_base(3'd4, 1'b0);
        send_base(3'd5, 1'b0);
        send_base(3'd7, 1'b0);
        // last mark off a codon boundary, bases continue after it
        send_base(3'd1, 1'b1);
        send_base(3'd2, 1'b0);
        send_base(3'd3, 1'b0);
        send_read(13'd6);
        send_read(13'd63);
        send_read(CODON_EXTRA_BIN);
        send_read(13'd27);
        send_read(DICODON_EXTRA_BIN);
        // reads past the store
        send_read(13'd4097);
        send_read(13'd8191);
        send_beat(MODE_UNUSED, 3'd7, 1'b1, 13'd8191);
        // start clears the sequence store but not the totals
        send_beat(MODE_START, 3'd0, 1'b0, 13'd0);
        send_read(13'd6);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            cfg_dicodon = ph[0];
            write_reg(REG_DICODON, ph[0]);
            write_reg(REG_SKIP, ph[1]);
            if (ph == PHASE_COUNT - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (ph == 2) begin
                // long receiver hold with reads offered back to back
                tx_idle_on = 1'b0;
                hold_req   = 1'b1;
                repeat (40) send_read(pick_read_bin());
                tx_idle_on = 1'b1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0)
                    run_noise();
                else
                    run_sequence();
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result sink: random stalls, plus the single long hold
    initial begin : result_sink
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where no beat and no register access goes through
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d reads outstanding", $time, pending);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule : tb_codon_usage_histogram

@@ filelist.f @@
rtl/cuh_pkg.sv
rtl/cuh_ram.sv
rtl/codon_usage_histogram.sv
tb/sv/codon_count_checker.sv
tb/sv/tb_codon_usage_histogram.sv
